// ===== sv/abvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abvp_pkg: shared types and constants for the accelerometer burst packer
// Holds the command codes, check constants, batch capacity and the record
// types passed between the checker, the counter unit and the top level.
// ----------------------------------------------------------------------------
package abvp_pkg;

  // Batch capacity in bytes; a report is due once another sample would not fit.
  localparam int unsigned BatchCapacityBytes = 52;

  // Fixed constants of the sensor protocol.
  localparam logic [7:0] CtlExpected   = 8'h90;
  localparam logic [3:0] NibbleOnes    = 4'hf;
  localparam logic [3:0] NibbleZeros   = 4'h0;
  localparam logic [6:0] StatusMax     = 7'd32;
  localparam logic [6:0] OverflowLevel = 7'd31;
  localparam logic [6:0] PollLevel     = 7'd1;
  localparam logic [3:0] SampleBytes   = 4'd5;

  // Command codes of an input transaction.
  typedef enum logic {
    CMD_PROCESS = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  // One burst response as held in the input register.
  typedef struct packed {
    cmd_e       command;
    logic [7:0] x_low;
    logic [7:0] x_high;
    logic [7:0] y_low;
    logic [7:0] y_high;
    logic [7:0] z_low;
    logic [7:0] z_high;
    logic [7:0] fifo_ctl_echo;
    logic [7:0] fifo_status_raw;
  } in_item_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [39:0] packed_sample;
    logic        data_error;
    logic [7:0]  batch_bytes;
    logic        batch_full;
    logic [15:0] overflow_count;
    logic        poll_again;
  } out_item_t;

  // Check status handed from the checker to the counter unit.
  typedef struct packed {
    logic restart;
    logic data_error;
    logic overflow_hit;
    logic poll_again;
  } chk_t;

endpackage

`default_nettype wire

// ===== sv/abvp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abvp_in_if / abvp_out_if: valid/ready channels of the burst packer
// The input channel carries one burst response, the output channel one
// packed result. A transaction completes when valid and ready are both high.
// ----------------------------------------------------------------------------
interface abvp_in_if;
  logic             valid;
  logic             ready;
  abvp_pkg::cmd_e   command;
  logic [7:0]       x_low;
  logic [7:0]       x_high;
  logic [7:0]       y_low;
  logic [7:0]       y_high;
  logic [7:0]       z_low;
  logic [7:0]       z_high;
  logic [7:0]       fifo_ctl_echo;
  logic [7:0]       fifo_status_raw;

  modport source (
    output valid, command, x_low, x_high, y_low, y_high, z_low, z_high,
           fifo_ctl_echo, fifo_status_raw,
    input  ready
  );
  modport sink (
    input  valid, command, x_low, x_high, y_low, y_high, z_low, z_high,
           fifo_ctl_echo, fifo_status_raw,
    output ready
  );
endinterface

interface abvp_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] packed_sample;
  logic        data_error;
  logic [7:0]  batch_bytes;
  logic        batch_full;
  logic [15:0] overflow_count;
  logic        poll_again;

  modport source (
    output valid, packed_sample, data_error, batch_bytes, batch_full,
           overflow_count, poll_again,
    input  ready
  );
  modport sink (
    input  valid, packed_sample, data_error, batch_bytes, batch_full,
           overflow_count, poll_again,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/accel_burst_validate_pack.sv =====
// An accepted transaction waits in the input register and moves into the result register
// once that register is empty or its own transaction completes.
// Throughput: one transaction per cycle while the sink keeps ready high; the input register
// feeds the result register through one level of check, pack and count logic.
// The count registers update as each sample enters the result register.
// Reset clears both counts and all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_burst_validate_pack: accelerometer burst check and sample packer
// Registers each burst response, validates and packs it, tracks the batch
// byte count and overflow count, and registers the result for the sink.
// ----------------------------------------------------------------------------
module accel_burst_validate_pack (
  input  logic        clk_i,
  input  logic        rst_ni,
  abvp_in_if.sink     in_if,
  abvp_out_if.source  out_if
);

  abvp_pkg::in_item_t  in_q;
  abvp_pkg::in_item_t  in_d;
  logic                in_valid_q;
  abvp_pkg::out_item_t out_q;
  abvp_pkg::out_item_t out_d;
  logic                out_valid_q;
  logic                advance;
  logic                step;
  abvp_pkg::chk_t      chk;
  logic [39:0]         packed_sample;
  logic [7:0]          batch_bytes;
  logic                batch_full;
  logic [15:0]         overflow_count;

  // The result register can load when empty or when its transaction completes.
  assign advance     = !out_valid_q || out_if.ready;
  assign step        = in_valid_q && advance;
  assign in_if.ready = !in_valid_q || advance;

  always_comb begin
    in_d.command         = in_if.command;
    in_d.x_low           = in_if.x_low;
    in_d.x_high          = in_if.x_high;
    in_d.y_low           = in_if.y_low;
    in_d.y_high          = in_if.y_high;
    in_d.z_low           = in_if.z_low;
    in_d.z_high          = in_if.z_high;
    in_d.fifo_ctl_echo   = in_if.fifo_ctl_echo;
    in_d.fifo_status_raw = in_if.fifo_status_raw;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_q <= in_d;
    end
  end

  abvp_check_pack u_check_pack (
    .item_i          (in_q),
    .packed_sample_o (packed_sample),
    .chk_o           (chk)
  );

  abvp_counters u_counters (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .chk_i            (chk),
    .batch_bytes_o    (batch_bytes),
    .batch_full_o     (batch_full),
    .overflow_count_o (overflow_count)
  );

  always_comb begin
    out_d.packed_sample  = packed_sample;
    out_d.data_error     = chk.data_error;
    out_d.batch_bytes    = batch_bytes;
    out_d.batch_full     = batch_full;
    out_d.overflow_count = overflow_count;
    out_d.poll_again     = chk.poll_again;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.packed_sample  = out_q.packed_sample;
  assign out_if.data_error     = out_q.data_error;
  assign out_if.batch_bytes    = out_q.batch_bytes;
  assign out_if.batch_full     = out_q.batch_full;
  assign out_if.overflow_count = out_q.overflow_count;
  assign out_if.poll_again     = out_q.poll_again;

  // A failed check always gives the all-ones sample and no poll request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.data_error |-> (out_q.packed_sample == '1) && !out_q.poll_again)
    else $error("error result without all-ones sample or with poll request");

  // A full batch means the next sample would exceed the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.batch_full |->
      ({2'd0, out_q.batch_bytes} + {6'd0, abvp_pkg::SampleBytes}) >
      10'(abvp_pkg::BatchCapacityBytes))
    else $error("batch flagged full below capacity");

  // A held input item stays put while the result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register changed during stall");

  // A stalled result stays put until its transaction completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(out_q))
    else $error("result register changed during stall");

endmodule

`default_nettype wire

// ===== sv/abvp_check_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abvp_check_pack: validation and packing of one burst response
// Checks sign extension, the control echo and the entry count, and packs the
// three 13-bit axes into five bytes, all ones when a check fails, all zeros on a restart.
// ----------------------------------------------------------------------------
module abvp_check_pack (
  input  abvp_pkg::in_item_t item_i,
  output logic [39:0]        packed_sample_o,
  output abvp_pkg::chk_t     chk_o
);

  logic       sign_ok;
  logic       ctl_ok;
  logic       status_ok;
  logic       err;
  logic [6:0] entries;
  logic [6:0] entries_eff;
  logic [7:0] byte3;
  logic [7:0] byte4;

  // The top nibble of each high byte must be all zeros or all ones.
  always_comb begin
    sign_ok = ((item_i.x_high[7:4] == abvp_pkg::NibbleZeros) ||
               (item_i.x_high[7:4] == abvp_pkg::NibbleOnes)) &&
              ((item_i.y_high[7:4] == abvp_pkg::NibbleZeros) ||
               (item_i.y_high[7:4] == abvp_pkg::NibbleOnes)) &&
              ((item_i.z_high[7:4] == abvp_pkg::NibbleZeros) ||
               (item_i.z_high[7:4] == abvp_pkg::NibbleOnes));
  end

  // The trigger bit of the status is ignored; the rest is the entry count.
  assign entries     = item_i.fifo_status_raw[6:0];
  assign ctl_ok      = (item_i.fifo_ctl_echo == abvp_pkg::CtlExpected);
  assign status_ok   = (entries <= abvp_pkg::StatusMax);
  assign err         = !(sign_ok && ctl_ok && status_ok);
  assign entries_eff = err ? 7'd0 : entries;

  // Upper axis bits share the last two bytes; Z is split across both.
  assign byte3 = {item_i.z_high[2:0], item_i.x_high[4:0]};
  assign byte4 = {1'b0, item_i.z_high[4:3], item_i.y_high[4:0]};

  // A restart yields an all-zero result.
  always_comb begin
    if (item_i.command == abvp_pkg::CMD_RESTART) begin
      packed_sample_o = '0;
    end else if (err) begin
      packed_sample_o = '1;
    end else begin
      packed_sample_o = {byte4, byte3, item_i.z_low, item_i.y_low, item_i.x_low};
    end
  end

  always_comb begin
    chk_o.restart      = (item_i.command == abvp_pkg::CMD_RESTART);
    chk_o.data_error   = !chk_o.restart && err;
    chk_o.overflow_hit = !chk_o.restart && (entries_eff >= abvp_pkg::OverflowLevel);
    chk_o.poll_again   = !chk_o.restart && (entries_eff > abvp_pkg::PollLevel);
  end

endmodule

`default_nettype wire

// ===== sv/abvp_counters.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abvp_counters: batch byte count and overflow count
// Adds five bytes per processed sample, flags a full batch and clears the
// count, and counts possible FIFO overflows. A restart clears both counts.
// ----------------------------------------------------------------------------
module abvp_counters (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  abvp_pkg::chk_t chk_i,
  output logic [7:0]     batch_bytes_o,
  output logic           batch_full_o,
  output logic [15:0]    overflow_count_o
);

  logic [7:0]  batch_q;
  logic [7:0]  batch_d;
  logic [15:0] ovf_q;
  logic [15:0] ovf_d;
  logic [8:0]  count;
  logic        full;

  // Bytes including this sample, and whether the next one would not fit.
  assign count = {1'b0, batch_q} + {5'd0, abvp_pkg::SampleBytes};
  assign full  = ({1'b0, count} + {6'd0, abvp_pkg::SampleBytes}) >
                 10'(abvp_pkg::BatchCapacityBytes);

  always_comb begin
    if (chk_i.restart) begin
      batch_d = '0;
      ovf_d   = '0;
    end else begin
      batch_d = full ? 8'd0 : count[7:0];
      ovf_d   = ovf_q + {15'd0, chk_i.overflow_hit};
    end
  end

  // Count state advances once per sample handed to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= '0;
      ovf_q   <= '0;
    end else if (step_i) begin
      batch_q <= batch_d;
      ovf_q   <= ovf_d;
    end
  end

  assign batch_bytes_o    = chk_i.restart ? 8'd0 : count[7:0];
  assign batch_full_o     = !chk_i.restart && full;
  assign overflow_count_o = ovf_d;

endmodule

`default_nettype wire
